// File: rtl/core/ica_pkg.sv
package ica_pkg;

  localparam int MAX_CORES_DEF    = 64;
  localparam int PROC_ID_BITS_DEF = 16;
  localparam int ACTIVE_BITS      = 7;

  localparam logic [2:0] KIND_ALLOC    = 3'd0;
  localparam logic [2:0] KIND_DEALLOC  = 3'd1;
  localparam logic [2:0] KIND_TAKE_ANY = 3'd2;
  localparam logic [2:0] KIND_TAKE_ONE = 3'd3;
  localparam logic [2:0] KIND_PUT_IDLE = 3'd4;
  localparam logic [2:0] KIND_TO_HEAD  = 3'd5;
  localparam logic [2:0] KIND_SET_PROV = 3'd6;
  localparam logic [2:0] KIND_BAD      = 3'd7;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  core_id;
    logic [15:0] proc_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] granted_core;
  } rsp_t;

endpackage

// File: rtl/core/ica_ram.sv
module ica_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int EW    = 47
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ica_ctrl.sv
module ica_ctrl
  import ica_pkg::*;
#(
  parameter int MAX_CORES    = MAX_CORES_DEF,
  parameter int PROC_ID_BITS = PROC_ID_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  req_t req,
  input  logic [((($clog2(MAX_CORES) + 1) > ACTIVE_BITS) ?
                 ($clog2(MAX_CORES) + 1) : ACTIVE_BITS) - 1:0] lim,
  output logic busy,
  output logic res_valid,
  output rsp_t res
);

  localparam int AW = $clog2(MAX_CORES);
  localparam int CW = AW + 1;
  localparam int LW = (CW > ACTIVE_BITS) ? CW : ACTIVE_BITS;
  localparam int PB = PROC_ID_BITS;
  localparam int EW = 1 + 2 * CW + 2 * PB;
  localparam logic [CW-1:0] NO_CORE = CW'(MAX_CORES);

  typedef struct packed {
    logic          idle;
    logic [CW-1:0] nxt;
    logic [CW-1:0] prv;
    logic [PB-1:0] owner;
    logic [PB-1:0] prov;
  } entry_t;

  typedef struct packed {
    logic          vld;
    logic [AW-1:0] addr;
    logic          is_next;
    logic [CW-1:0] val;
  } patch_t;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_READ     = 9'b000000100,
    S_DECIDE   = 9'b000001000,
    S_WALK_RD  = 9'b000010000,
    S_WALK_CHK = 9'b000100000,
    S_PATCH_RD = 9'b001000000,
    S_PATCH_WR = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE   = 4'b0001,
    ACT_SET    = 4'b0010,
    ACT_UNLINK = 4'b0100,
    ACT_TAIL   = 4'b1000
  } act_t;

  state_t state, state_next;
  logic [AW-1:0] clr;
  logic [CW-1:0] head, tail, cur, steps;
  logic [2:0] kind;
  logic [LW-1:0] cid;
  logic [PB-1:0] pid;
  patch_t pq [3];
  logic [1:0] psel;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  entry_t e, clr_e, self_e, patch_e;

  act_t act;
  logic to_head;
  logic [PB-1:0] owner_n, prov_n;
  logic [1:0] status_n;
  logic [CW-1:0] tgt, u_head, u_tail, head_n, tail_n;
  patch_t pn [3];
  logic found;
  logic [CW-1:0] steps_inc;
  logic [1:0] first_sel;
  logic more;

  ica_ram #(.DEPTH(MAX_CORES), .AW(AW), .EW(EW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign e    = entry_t'(rdata);
  assign busy = (state != S_IDLE);

  // reset image of one entry: ascending chain over cores 1 .. MAX-1
  always_comb begin
    clr_e.idle  = (clr != '0);
    clr_e.nxt   = (clr == '0) ? NO_CORE : CW'(clr) + CW'(1);
    clr_e.prv   = (CW'(clr) <= CW'(1)) ? NO_CORE : CW'(clr) - CW'(1);
    clr_e.owner = '0;
    clr_e.prov  = '0;
  end

  assign tgt       = (state == S_WALK_CHK) ? cur : cid[CW-1:0];
  assign found     = (e.prov == '0) && (LW'(cur) < lim);
  assign steps_inc = steps + CW'(1);

  // request decision on the entry just read
  always_comb begin
    act      = ACT_NONE;
    to_head  = 1'b0;
    owner_n  = e.owner;
    prov_n   = e.prov;
    status_n = ST_DONE;
    if (state == S_WALK_CHK) begin
      if (e.owner != '0) begin
        status_n = ST_ERR;
      end else begin
        act = ACT_UNLINK;
      end
    end else begin
      case (kind)
        KIND_ALLOC: begin
          if (!e.idle || e.owner == pid) begin
            status_n = ST_ERR;
          end else begin
            act     = ACT_UNLINK;
            owner_n = pid;
          end
        end
        KIND_DEALLOC: begin
          if (e.idle) begin
            status_n = ST_ERR;
          end else begin
            act     = ACT_TAIL;
            owner_n = '0;
          end
        end
        KIND_TAKE_ONE: begin
          if (!e.idle || e.prov != '0) begin
            status_n = ST_NONE;
          end else if (e.owner != '0) begin
            status_n = ST_ERR;
          end else begin
            act = ACT_UNLINK;
          end
        end
        KIND_PUT_IDLE: begin
          if (e.idle) begin
            status_n = ST_ERR;
          end else begin
            act = ACT_TAIL;
          end
        end
        KIND_TO_HEAD: begin
          if (!e.idle) begin
            status_n = ST_NONE;
          end else begin
            act     = ACT_UNLINK;
            to_head = 1'b1;
          end
        end
        KIND_SET_PROV: begin
          act    = ACT_SET;
          prov_n = pid;
        end
        default: status_n = ST_ERR;
      endcase
    end
  end

  // list edits: new self entry, neighbor patches, new head and tail
  always_comb begin
    u_head = (e.prv < NO_CORE) ? head : e.nxt;
    u_tail = (e.nxt < NO_CORE) ? tail : e.prv;
    self_e = e;
    self_e.owner = owner_n;
    self_e.prov  = prov_n;
    head_n = head;
    tail_n = tail;
    for (int i = 0; i < 3; i++) begin
      pn[i] = '0;
    end
    case (act)
      ACT_UNLINK: begin
        pn[0] = '{vld: (e.prv < NO_CORE), addr: e.prv[AW-1:0], is_next: 1'b1, val: e.nxt};
        pn[1] = '{vld: (e.nxt < NO_CORE), addr: e.nxt[AW-1:0], is_next: 1'b0, val: e.prv};
        if (to_head) begin
          self_e.idle = 1'b1;
          self_e.nxt  = u_head;
          self_e.prv  = NO_CORE;
          pn[2] = '{vld: (u_head < NO_CORE), addr: u_head[AW-1:0], is_next: 1'b0,
                    val: tgt};
          head_n = tgt;
          tail_n = (u_head < NO_CORE) ? u_tail : tgt;
        end else begin
          self_e.idle = 1'b0;
          self_e.nxt  = NO_CORE;
          self_e.prv  = NO_CORE;
          head_n = u_head;
          tail_n = u_tail;
        end
      end
      ACT_TAIL: begin
        self_e.idle = 1'b1;
        self_e.nxt  = NO_CORE;
        self_e.prv  = tail;
        pn[2] = '{vld: (tail < NO_CORE), addr: tail[AW-1:0], is_next: 1'b1, val: tgt};
        head_n = (tail < NO_CORE) ? head : tgt;
        tail_n = tgt;
      end
      default: ;
    endcase
  end

  // patch selection
  always_comb begin
    first_sel = pq[0].vld ? 2'd0 : (pq[1].vld ? 2'd1 : 2'd2);
    more = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (pq[i].vld && i != int'(psel)) begin
        more = 1'b1;
      end
    end
    patch_e = e;
    if (pq[psel].is_next) begin
      patch_e.nxt = pq[psel].val;
    end else begin
      patch_e.prv = pq[psel].val;
    end
  end

  // memory ports
  always_comb begin
    we    = 1'b0;
    waddr = clr;
    wdata = EW'(clr_e);
    raddr = cid[AW-1:0];
    case (state)
      S_CLEAR: we = 1'b1;
      S_DECIDE, S_WALK_CHK: begin
        we    = (act != ACT_NONE) && (state == S_DECIDE || found);
        waddr = tgt[AW-1:0];
        wdata = EW'(self_e);
      end
      S_WALK_RD:  raddr = cur[AW-1:0];
      S_PATCH_RD: raddr = pq[first_sel].addr;
      S_PATCH_WR: begin
        we    = 1'b1;
        waddr = pq[psel].addr;
        wdata = EW'(patch_e);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == AW'(MAX_CORES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (go) begin
          if (req.kind == KIND_TAKE_ANY) begin
            state_next = (head < NO_CORE) ? S_WALK_RD : S_FINISH;
          end else if (req.kind == KIND_BAD || LW'(req.core_id) >= lim) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ:  state_next = S_DECIDE;
      S_DECIDE: begin
        state_next = (pn[0].vld || pn[1].vld || pn[2].vld) ? S_PATCH_RD : S_FINISH;
      end
      S_WALK_RD: state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        if (found) begin
          state_next = (pn[0].vld || pn[1].vld || pn[2].vld) ? S_PATCH_RD : S_FINISH;
        end else if (e.nxt >= NO_CORE || steps_inc >= NO_CORE) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_PATCH_RD: state_next = S_PATCH_WR;
      S_PATCH_WR: state_next = more ? S_PATCH_RD : S_FINISH;
      S_FINISH:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      head  <= CW'(1);
      tail  <= CW'(MAX_CORES - 1);
      for (int i = 0; i < 3; i++) begin
        pq[i].vld <= 1'b0;
      end
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: clr <= clr + AW'(1);
        S_IDLE: begin
          if (go) begin
            kind  <= req.kind;
            cid   <= LW'(req.core_id);
            pid   <= PB'(req.proc_id);
            cur   <= head;
            steps <= '0;
            if (req.kind == KIND_TAKE_ANY) begin
              res <= '{status: ST_NONE, granted_core: 6'd0};
            end else if (req.kind == KIND_BAD || LW'(req.core_id) >= lim) begin
              res <= '{status: ST_ERR, granted_core: req.core_id};
            end else begin
              res.granted_core <= req.core_id;
            end
          end
        end
        S_DECIDE: begin
          res.status <= status_n;
          head <= head_n;
          tail <= tail_n;
          for (int i = 0; i < 3; i++) begin
            pq[i] <= pn[i];
          end
        end
        S_WALK_CHK: begin
          if (found) begin
            res <= '{status: status_n, granted_core: 6'(LW'(cur))};
            head <= head_n;
            tail <= tail_n;
            for (int i = 0; i < 3; i++) begin
              pq[i] <= pn[i];
            end
          end else begin
            cur   <= e.nxt;
            steps <= steps_inc;
          end
        end
        S_PATCH_RD: psel <= first_sel;
        S_PATCH_WR: pq[psel].vld <= 1'b0;
        default: ;
      endcase
    end
  end

  assign res_valid = (state == S_FINISH);

endmodule

// File: rtl/core/idle_core_allocator.sv
// Channel   Signals                 Handshake
// request   req (kind/core/proc)    transfer when start & !busy
// response  rsp (status/granted)    one-cycle done strobe, no backpressure
// config    cfg_wdata (active)      transfer when cfg_we, write only
//
// One request at a time. A named-core request reads its entry, decides,
// then reads and writes each neighbor patch (up to 3 patches); range
// errors, an unknown kind and a take-any on an empty list go straight to
// finish. Take-any walks the idle list through the entry RAM read port,
// one read and one check per visited entry, at most MAX_CORES entries.
// After reset a clearing pass over the MAX_CORES entries rebuilds the
// chain; busy stays high meanwhile. Response appears the cycle after finish.
module idle_core_allocator
  import ica_pkg::*;
#(
  parameter int MAX_CORES    = MAX_CORES_DEF,
  parameter int PROC_ID_BITS = PROC_ID_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       done,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_CORES) + 1;
  localparam int LW = (CW > ACTIVE_BITS) ? CW : ACTIVE_BITS;

  // active core count, reset to the full population
  logic [LW-1:0] active;
  logic [LW-1:0] lim;
  logic          res_valid;
  rsp_t          res;

  assign lim = (active < LW'(MAX_CORES)) ? active : LW'(MAX_CORES);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= LW'(MAX_CORES);
    end else if (cfg_we) begin
      active <= LW'(cfg_wdata);
    end
  end

  ica_ctrl #(.MAX_CORES(MAX_CORES), .PROC_ID_BITS(PROC_ID_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .go       (start && !busy),
    .req      (req),
    .lim      (lim),
    .busy     (busy),
    .res_valid(res_valid),
    .res      (res)
  );

  // response register: one strobe per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
    rsp <= res;
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("response without work in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_DONE || rsp.status == ST_NONE || rsp.status == ST_ERR))
    else $error("bad status code");

endmodule

// File: tb/sv/idle_core_allocator_checker.sv
module idle_core_allocator_checker
  import ica_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  req_t       req,
  input  logic       done,
  input  rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCORE = 64;
  localparam int NIL   = NCORE;

  // shadow of the idle list and owner tables
  logic        listed [NCORE];
  int          fwd [NCORE];
  int          bwd [NCORE];
  int          head_c, tail_c;
  logic [15:0] owner [NCORE];
  logic [15:0] prov [NCORE];
  logic [6:0]  num_active;
  rsp_t        rsp_due [$];

  function automatic void unhook(int c);
    int pv, nx;
    pv = bwd[c];
    nx = fwd[c];
    if (pv < NCORE) fwd[pv] = nx; else head_c = nx;
    if (nx < NCORE) bwd[nx] = pv; else tail_c = pv;
    fwd[c] = NIL;
    bwd[c] = NIL;
    listed[c] = 1'b0;
  endfunction

  function automatic void hook_tail(int c);
    bwd[c] = tail_c;
    fwd[c] = NIL;
    if (tail_c < NCORE) fwd[tail_c] = c; else head_c = c;
    tail_c = c;
    listed[c] = 1'b1;
  endfunction

  function automatic void hook_head(int c);
    fwd[c] = head_c;
    bwd[c] = NIL;
    if (head_c < NCORE) bwd[head_c] = c; else tail_c = c;
    head_c = c;
    listed[c] = 1'b1;
  endfunction

  function automatic void clear_shadow();
    num_active = 7'd64;
    head_c = NIL;
    tail_c = NIL;
    for (int i = 0; i < NCORE; i++) begin
      listed[i] = 1'b0;
      fwd[i] = NIL;
      bwd[i] = NIL;
      owner[i] = '0;
      prov[i] = '0;
    end
    for (int i = 1; i < NCORE; i++) hook_tail(i);
  endfunction

  function automatic rsp_t allocate_step(req_t r);
    rsp_t o;
    int c, lim, cur, steps;
    c = r.core_id;
    lim = (num_active < NCORE) ? num_active : NCORE;
    o.status = ST_DONE;
    o.granted_core = r.core_id;
    if (r.kind == KIND_TAKE_ANY) begin
      cur = head_c;
      steps = 0;
      o.status = ST_NONE;
      o.granted_core = '0;
      while (cur < NCORE && steps < NCORE) begin
        if (prov[cur] == 0 && cur < lim) begin
          o.granted_core = cur[5:0];
          if (owner[cur] != 0) o.status = ST_ERR;
          else begin
            unhook(cur);
            o.status = ST_DONE;
          end
          break;
        end
        cur = fwd[cur];
        steps++;
      end
    end else if (r.kind > KIND_SET_PROV || c >= lim) begin
      o.status = ST_ERR;
    end else begin
      case (r.kind)
        KIND_ALLOC: begin
          if (!listed[c] || owner[c] == r.proc_id) o.status = ST_ERR;
          else begin
            owner[c] = r.proc_id;
            unhook(c);
          end
        end
        KIND_DEALLOC: begin
          if (listed[c]) o.status = ST_ERR;
          else begin
            owner[c] = '0;
            hook_tail(c);
          end
        end
        KIND_TAKE_ONE: begin
          if (!listed[c] || prov[c] != 0) o.status = ST_NONE;
          else if (owner[c] != 0) o.status = ST_ERR;
          else unhook(c);
        end
        KIND_PUT_IDLE: begin
          if (listed[c]) o.status = ST_ERR;
          else hook_tail(c);
        end
        KIND_TO_HEAD: begin
          if (!listed[c]) o.status = ST_NONE;
          else begin
            unhook(c);
            hook_head(c);
          end
        end
        default: prov[c] = r.proc_id;
      endcase
    end
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    clear_shadow();
  end

  assign pending = rsp_due.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      clear_shadow();
      rsp_due.delete();
    end else begin
      if (done) begin
        if (rsp_due.size() == 0) begin
          report_mismatch($sformatf("unexpected response %0d/%0d",
                                    rsp.status, rsp.granted_core));
        end else begin
          want = rsp_due.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d want %0d", rsp.status, want.status));
          if (rsp.granted_core !== want.granted_core)
            report_mismatch($sformatf("granted_core %0d want %0d",
                                      rsp.granted_core, want.granted_core));
        end
      end
      if (cfg_we) num_active = cfg_wdata;
      if (start && !busy) rsp_due.push_back(allocate_step(req));
    end
  end
endmodule

// File: tb/sv/idle_core_allocator_tb.sv
module idle_core_allocator_tb;
  import ica_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;  // watchdog limit, above the longest take-any walk

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  req_t       req;
  logic       done;
  rsp_t       rsp;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         quiet_cycles;
  bit         no_gaps;

  idle_core_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  idle_core_allocator_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: counts cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One request transfer; random idle cycles ahead of it unless in the no-gap stretch.
  // start stays up after the transfer; the next call or a drain decides its level.
  task automatic send_req(logic [2:0] k, logic [5:0] c, logic [15:0] p);
    while (!no_gaps && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= '{kind: k, core_id: c, proc_id: p};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain outstanding responses, then give a trailing item time to finish.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic set_active(logic [6:0] n);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_proc();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF, 1));
    endcase
  endfunction

  // Mostly live-core requests; a few out of range or an unknown kind.
  task automatic random_req(int hi);
    logic [2:0]  k;
    logic [5:0]  c;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 3) k = KIND_BAD;
    else if (pick < 25) k = KIND_ALLOC;
    else if (pick < 45) k = KIND_DEALLOC;
    else if (pick < 60) k = KIND_TAKE_ANY;
    else if (pick < 72) k = KIND_TAKE_ONE;
    else if (pick < 82) k = KIND_PUT_IDLE;
    else if (pick < 90) k = KIND_TO_HEAD;
    else k = KIND_SET_PROV;
    c = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(hi));
    // provisioning mostly cleared so take-any keeps finding cores
    send_req(k, c, (k == KIND_SET_PROV && $urandom_range(2) != 0) ? 16'd0 : rand_proc());
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = 7'd64;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every kind, field extremes, each corner case
    send_req(KIND_ALLOC, 6'd0, 16'd5);         // management core not listed
    send_req(KIND_ALLOC, 6'd63, 16'd0);        // proc 0 on free core
    send_req(KIND_ALLOC, 6'd63, 16'hFFFF);
    send_req(KIND_ALLOC, 6'd63, 16'h1234);     // not listed any more
    send_req(KIND_DEALLOC, 6'd1, 16'd0);       // already listed
    send_req(KIND_PUT_IDLE, 6'd2, 16'd0);      // already listed
    send_req(KIND_SET_PROV, 6'd1, 16'hA5A5);
    send_req(KIND_TAKE_ONE, 6'd1, 16'd0);      // provisioned
    send_req(KIND_TAKE_ANY, 6'd0, 16'd0);      // skips core 1
    send_req(KIND_TAKE_ONE, 6'd2, 16'd0);      // taken already
    send_req(KIND_TO_HEAD, 6'd2, 16'd0);       // not listed
    send_req(KIND_PUT_IDLE, 6'd63, 16'd0);     // back with owner kept
    send_req(KIND_TO_HEAD, 6'd63, 16'd0);
    send_req(KIND_TAKE_ANY, 6'd0, 16'd0);      // owned head core
    send_req(KIND_TAKE_ONE, 6'd63, 16'd0);     // owned
    send_req(KIND_DEALLOC, 6'd2, 16'd0);
    send_req(KIND_BAD, 6'd3, 16'd0);           // unknown kind
    send_req(KIND_SET_PROV, 6'd1, 16'd0);

    set_active(7'd1);
    send_req(KIND_ALLOC, 6'd1, 16'd7);         // out of range
    send_req(KIND_TAKE_ANY, 6'd0, 16'd0);      // nothing eligible
    set_active(7'd0);
    send_req(KIND_SET_PROV, 6'd0, 16'd9);
    set_active(7'd127);
    send_req(KIND_TAKE_ONE, 6'd63, 16'd0);

    // random phases at several core counts; one stretch with no idling
    for (int ph = 0; ph < 5; ph++) begin
      int n;
      n = (ph == 0) ? 64 : (ph == 1) ? 8 : (ph == 2) ? 2 : (ph == 3) ? 40 : 127;
      set_active(7'(n));
      no_gaps = (ph == 3);
      for (int i = 0; i < 90; i++) begin
        random_req((n > 63) ? 63 : ((n > 1) ? n - 1 : 1));
        if (i == 45) wait_idle();  // sender holds off until all responses are in
      end
    end
    no_gaps = 1'b0;

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
